[rtl/fdc_pkg.sv]
`default_nettype none

package fdc_pkg;

   // Table sizes, in fragments.
   localparam int unsigned QUAD_SIZE   = 64;
   localparam int unsigned TRIPLE_SIZE = 64;
   localparam int unsigned PAIR_SIZE   = 128;

   // Default fragment counts.
   localparam int unsigned QUAD_COUNT_DEF   = 28;
   localparam int unsigned TRIPLE_COUNT_DEF = 5;
   localparam int unsigned PAIR_COUNT_DEF   = 95;

   // Codes at and above this value are fragment codes.
   localparam int unsigned CODE_BASE = 128;

   // One step leaves at most this many codes.
   localparam int unsigned MAX_PUSH = 4;

   // Result queue depth; a power of two of at least MAX_PUSH.
   localparam int unsigned QUEUE_DEPTH = 8;

   localparam logic [8*QUAD_SIZE*4-1:0] QUAD_TEXT = {
      " thethe  You The of . Th is ing You hereThe  areare  in ere n th",
      "f th to of tre iand  andall is aou a youu aro the iss a ssagsage",
      " a sassa herTher walhe she fmalle nosmal smaorthoom passeastwall",
      "to t. Yoin tre. nort pas norave . A n't  fro can leahe wweste. T"};

   localparam logic [8*TRIPLE_SIZE*3-1:0] TRIPLE_TEXT = {
      "he  ththere  a  Th. Tou  ofYou YoingTheereng of ",
      "heris  isnd alls aed e ie.  an inareand arto e s",
      " toin  non tge om f t paer es  heth e aave coll ",
      "e w waagest u a havere oe fyouo t yo caear onass"};

   localparam logic [8*PAIR_SIZE*2-1:0] PAIR_TEXT = {
      "e heth t a. s reouinerd t  on  s iarana st c wisear ornd Tng hon",
      " falroThf esooofu Yo Y ledveg astoeny omgellteha ro at plole bl ",
      " nh  d eitnonee.lisedem wassraelntpacomaowadlahiurutavriagdi mbe",
      "saiccartpeceus y Adoolsoyoeeweunsiidcht., ck gsmnswitahornacrsti"};

   typedef logic [6:0] char_type;

   // Result of matching the four window characters.
   typedef struct packed {
      logic [7:0] code;
      logic [2:0] used;
   } match_type;

   // One code waiting to be delivered.
   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } entry_type;

   // The codes one step hands to the result queue.
   typedef struct packed {
      entry_type [MAX_PUSH-1:0] slot;
      logic [2:0]               count;
   } push_type;

   function automatic char_type quad_char(input int unsigned i, input int unsigned k);
      return QUAD_TEXT[8*(QUAD_SIZE*4-1-(i*4+k)) +: 7];
   endfunction

   function automatic char_type triple_char(input int unsigned i, input int unsigned k);
      return TRIPLE_TEXT[8*(TRIPLE_SIZE*3-1-(i*3+k)) +: 7];
   endfunction

   function automatic char_type pair_char(input int unsigned i, input int unsigned k);
      return PAIR_TEXT[8*(PAIR_SIZE*2-1-(i*2+k)) +: 7];
   endfunction

endpackage

`default_nettype wire

[rtl/fdc_matcher.sv]
`default_nettype none

module fdc_matcher #(
   parameter int unsigned QUAD_COUNT   = fdc_pkg::QUAD_COUNT_DEF,
   parameter int unsigned TRIPLE_COUNT = fdc_pkg::TRIPLE_COUNT_DEF,
   parameter int unsigned PAIR_COUNT   = fdc_pkg::PAIR_COUNT_DEF
) (
   input  fdc_pkg::char_type  win [4],
   output fdc_pkg::match_type match
);
   import fdc_pkg::*;

   // Counts above a table's size are held to the size.
   localparam int unsigned NQ = (QUAD_COUNT < QUAD_SIZE) ? QUAD_COUNT : QUAD_SIZE;
   localparam int unsigned NT = (TRIPLE_COUNT < TRIPLE_SIZE) ? TRIPLE_COUNT : TRIPLE_SIZE;
   localparam int unsigned NP = (PAIR_COUNT < PAIR_SIZE) ? PAIR_COUNT : PAIR_SIZE;

   localparam logic [7:0] QUAD_BASE   = 8'(CODE_BASE % 256);
   localparam logic [7:0] TRIPLE_BASE = 8'((CODE_BASE + QUAD_COUNT) % 256);
   localparam logic [7:0] PAIR_BASE   = 8'((CODE_BASE + QUAD_COUNT + TRIPLE_COUNT) % 256);

   logic [QUAD_SIZE-1:0]   quad_hit;
   logic [TRIPLE_SIZE-1:0] triple_hit;
   logic [PAIR_SIZE-1:0]   pair_hit;

   for (genvar i = 0; i < QUAD_SIZE; i++) begin : g_quad
      assign quad_hit[i] = (i < NQ) &&
                           win[0] == quad_char(i, 0) && win[1] == quad_char(i, 1) &&
                           win[2] == quad_char(i, 2) && win[3] == quad_char(i, 3);
   end

   for (genvar i = 0; i < TRIPLE_SIZE; i++) begin : g_triple
      assign triple_hit[i] = (i < NT) &&
                             win[0] == triple_char(i, 0) && win[1] == triple_char(i, 1) &&
                             win[2] == triple_char(i, 2);
   end

   for (genvar i = 0; i < PAIR_SIZE; i++) begin : g_pair
      assign pair_hit[i] = (i < NP) &&
                           win[0] == pair_char(i, 0) && win[1] == pair_char(i, 1);
   end

   logic [5:0] quad_idx;
   logic [5:0] triple_idx;
   logic [6:0] pair_idx;

   // The lowest matching index wins within each table.
   always_comb begin
      quad_idx   = '0;
      triple_idx = '0;
      pair_idx   = '0;
      for (int i = QUAD_SIZE - 1; i >= 0; i--) begin
         if (quad_hit[i]) quad_idx = 6'(i);
      end
      for (int i = TRIPLE_SIZE - 1; i >= 0; i--) begin
         if (triple_hit[i]) triple_idx = 6'(i);
      end
      for (int i = PAIR_SIZE - 1; i >= 0; i--) begin
         if (pair_hit[i]) pair_idx = 7'(i);
      end
   end

   // Longer fragments take precedence over shorter ones.
   always_comb begin
      if (|quad_hit) begin
         match.code = QUAD_BASE + {2'b00, quad_idx};
         match.used = 3'd4;
      end else if (|triple_hit) begin
         match.code = TRIPLE_BASE + {2'b00, triple_idx};
         match.used = 3'd3;
      end else if (|pair_hit) begin
         match.code = PAIR_BASE + {1'b0, pair_idx};
         match.used = 3'd2;
      end else begin
         match.code = {1'b0, win[0]};
         match.used = 3'd1;
      end
   end

endmodule

`default_nettype wire

[rtl/fdc_queue.sv]
`default_nettype none

module fdc_queue (
   input  logic               clock,
   input  logic               reset,
   input  fdc_pkg::push_type  push,
   input  logic               take,
   output fdc_pkg::entry_type head,
   output logic               filled,
   output logic               room
);
   import fdc_pkg::*;

   localparam int unsigned PW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = PW + 1;

   entry_type       mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;

   assign head   = mem_ff[rd_ff];
   assign filled = (count_ff != '0);
   // Room for a full step is checked against the current fill alone.
   assign room   = (count_ff <= CW'(QUEUE_DEPTH - MAX_PUSH));

   always_comb begin
      wr_in    = wr_ff + PW'(push.count);
      rd_in    = rd_ff + PW'(take);
      count_in = count_ff + CW'(push.count) - CW'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_entry
      logic [PW-1:0] offset;
      assign offset = PW'(i) - wr_ff;
      always_ff @(posedge clock) begin
         if (CW'(offset) < CW'(push.count)) begin
            mem_ff[i] <= push.slot[offset[1:0]];
         end
      end
   end

endmodule

`default_nettype wire

[rtl/fragment_dictionary_compressor_top.sv]
`default_nettype none

// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_text_byte[6:0], req_end_of_text
// rsp       out        rsp_valid/stall    rsp_code_byte[7:0], rsp_last_code
//
// One text byte is taken per cycle while req_stall is low; the window update and
// fragment match are combinational, bounded by the parallel table compare in the
// matcher. Each transfer pushes zero to four codes into an eight-entry result
// queue that delivers one code per cycle while rsp_stall is low; an end of text
// can push up to four at once. req_stall rises while the queue holds more than
// four codes. Reset empties the window and the result queue.

module fragment_dictionary_compressor_top #(
   parameter int unsigned QUAD_COUNT   = fdc_pkg::QUAD_COUNT_DEF,
   parameter int unsigned TRIPLE_COUNT = fdc_pkg::TRIPLE_COUNT_DEF,
   parameter int unsigned PAIR_COUNT   = fdc_pkg::PAIR_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [6:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_code_byte,
   output logic       rsp_last_code
);
   import fdc_pkg::*;

   // Pending characters of the current text and how many are held.
   char_type   window_ff [3];
   char_type   window_in [3];
   logic [1:0] count_ff, count_in;

   logic       accept;
   logic       room;
   logic       take;
   char_type   win [4];
   logic [2:0] avail;
   logic       full_window;
   match_type  match;
   logic [2:0] used;
   char_type   lit [4];
   logic [2:0] left;
   push_type   push;
   entry_type  head;

   assign accept = req_valid && room;
   assign req_stall = !room;

   // The new byte lands right after the pending characters.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win[k] = (count_ff == 2'(k)) ? req_text_byte : window_ff[k];
      end
      win[3] = req_text_byte;
   end

   assign avail = {1'b0, count_ff} + 3'd1;
   assign full_window = (avail == 3'd4);

   fdc_matcher #(
      .QUAD_COUNT  (QUAD_COUNT),
      .TRIPLE_COUNT(TRIPLE_COUNT),
      .PAIR_COUNT  (PAIR_COUNT)
   ) u_matcher (
      .win  (win),
      .match(match)
   );

   // Characters not consumed by a match, in order. They either stay in the
   // window or, at the end of a text, leave as literals.
   assign used = full_window ? match.used : 3'd0;
   assign left = avail - used;

   always_comb begin
      logic [2:0] pos;
      for (int k = 0; k < 4; k++) begin
         pos = used + 3'(k);
         lit[k] = win[pos[1:0]];
      end
   end

   always_comb begin
      logic [2:0] n;
      push = '0;
      n = '0;
      if (full_window) begin
         push.slot[0].code = match.code;
         n = 3'd1;
      end
      if (req_end_of_text) begin
         for (int k = 0; k < 3; k++) begin
            if (3'(k) < left) begin
               push.slot[2'(n) + 2'(k)].code = {1'b0, lit[k]};
            end
         end
         n = n + left;
         if (n != '0) begin
            push.slot[2'(n - 3'd1)].last = 1'b1;
         end
      end
      push.count = accept ? n : 3'd0;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         window_in[k] = lit[k];
      end
      count_in = req_end_of_text ? 2'd0 : left[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

   assign take = rsp_valid && !rsp_stall;

   fdc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .take  (take),
      .head  (head),
      .filled(rsp_valid),
      .room  (room)
   );

   assign rsp_code_byte = head.code;
   assign rsp_last_code = head.last;

endmodule

`default_nettype wire
